/* hdl/lbpm_pkg.sv */
// ----------------------------------------------------------------------------
// lbpm_pkg
// Shared sizes, types and register codes of the light bar pair matcher.
// ----------------------------------------------------------------------------
package lbpm_pkg;

    // bar store capacity of one set
    localparam int MAX_BARS   = 8;
    localparam int IDX_W      = $clog2(MAX_BARS);
    localparam int CNT_W      = $clog2(MAX_BARS + 1);
    // second pair index ends the sweep at the count, one past it for an empty set
    localparam int J_W        = $clog2(MAX_BARS + 2);

    // two store banks: one loads while the other is swept
    localparam int NUM_BANKS  = 2;
    localparam int BANK_W     = $clog2(NUM_BANKS);
    localparam int OUT_W      = $clog2(NUM_BANKS + 1);
    localparam int QPTR_W     = $clog2(NUM_BANKS);
    localparam int RAM_AW     = BANK_W + IDX_W;
    localparam int RAM_DEPTH  = 1 << RAM_AW;

    localparam int COORD_W    = 16;
    localparam int ANGLE_W    = 12;
    localparam int DIST_W     = 16;
    localparam int ADIFF_W    = 12;
    localparam int SQ_W       = 2 * COORD_W;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HDIFF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANG_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANG_HIGH  = 3'd4;

    localparam logic [DIST_W-1:0]  RST_MIN_DIST  = 16'd1296;
    localparam logic [DIST_W-1:0]  RST_MAX_DIST  = 16'd3024;
    localparam logic [DIST_W-1:0]  RST_MAX_HDIFF = 16'd293;
    localparam logic [ADIFF_W-1:0] RST_ANG_LOW   = 12'd240;
    localparam logic [ADIFF_W-1:0] RST_ANG_HIGH  = 12'd2640;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle;
        logic [COORD_W-1:0]        y;
        logic [COORD_W-1:0]        x;
    } t_bar;

    // one closed set handed from the loader to the sweep
    typedef struct packed {
        logic [BANK_W-1:0] bank;
        logic [CNT_W-1:0]  count;
        logic              ovf;
    } t_set;

endpackage

/* hdl/light_bar_pair_matcher.sv */
// ----------------------------------------------------------------------------
// light_bar_pair_matcher
// Loads light bar sets and emits the bar pairs that pass the angle,
// distance and height tests.
// ----------------------------------------------------------------------------
//  channel | valid / stall              | payload
//  bars in | i_in_valid / o_in_stall    | i_center_x, i_center_y, i_tilt_angle,
//          |                            | i_last_bar
//  pairs   | o_out_valid / i_out_stall  | o_left_index .. o_last_pair
//  config  | i_cfg_we (no stall)        | i_cfg_idx, i_cfg_wdata
//
// Bars load one per cycle while o_in_stall is low into one of two store banks;
// a set of n stored bars gives P = n*(n-1)/2 pairs, swept one pair test per
// cycle while the output does not stall. The final result of a set follows its
// closing transfer: queue pop, P tests, end marker read, three test stages,
// output reg. The next set loads while the previous one is swept; o_in_stall
// rises only when both banks hold sets still waiting for or under sweep.
// A stalled output freezes the sweep pipeline. Reset needs no clearing pass.
// ----------------------------------------------------------------------------
module light_bar_pair_matcher import lbpm_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [COORD_W-1:0]      i_center_x,
    input  logic [COORD_W-1:0]      i_center_y,
    input  logic signed [ANGLE_W-1:0] i_tilt_angle,
    input  logic                    i_last_bar,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [IDX_W-1:0]        o_left_index,
    output logic [IDX_W-1:0]        o_right_index,
    output logic [COORD_W-1:0]      o_left_x,
    output logic [COORD_W-1:0]      o_left_y,
    output logic [COORD_W-1:0]      o_right_x,
    output logic [COORD_W-1:0]      o_right_y,
    output logic                    o_pair_valid,
    output logic                    o_bars_dropped,
    output logic                    o_last_pair
);

    t_bar              w_bar;
    logic              w_we;
    logic [RAM_AW-1:0] w_waddr;
    t_bar              w_wdata;
    logic              w_push;
    t_set              w_set;
    logic              w_done;
    logic              w_pop;
    logic              w_q_empty;
    t_set              w_q_head;
    logic              w_re;
    logic [RAM_AW-1:0] w_raddr_a;
    logic [RAM_AW-1:0] w_raddr_b;
    logic [$bits(t_bar)-1:0] w_rdata_a;
    logic [$bits(t_bar)-1:0] w_rdata_b;

    assign w_bar = '{angle: i_tilt_angle, y: i_center_y, x: i_center_x};

    lbpm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_bar      (w_bar),
        .i_last_bar (i_last_bar),
        .o_we       (w_we),
        .o_waddr    (w_waddr),
        .o_wdata    (w_wdata),
        .o_push     (w_push),
        .o_set      (w_set),
        .i_done     (w_done)
    );

    lbpm_ram #(
        .WIDTH ($bits(t_bar)),
        .DEPTH (RAM_DEPTH)
    ) u_bar_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_re      (w_re),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    lbpm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_set   (w_set),
        .i_pop   (w_pop),
        .o_empty (w_q_empty),
        .o_head  (w_q_head)
    );

    lbpm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_q_empty      (w_q_empty),
        .i_q_head       (w_q_head),
        .o_q_pop        (w_pop),
        .o_re           (w_re),
        .o_raddr_a      (w_raddr_a),
        .o_raddr_b      (w_raddr_b),
        .i_bar_a        (t_bar'(w_rdata_a)),
        .i_bar_b        (t_bar'(w_rdata_b)),
        .o_done         (w_done),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_left_index   (o_left_index),
        .o_right_index  (o_right_index),
        .o_left_x       (o_left_x),
        .o_left_y       (o_left_y),
        .o_right_x      (o_right_x),
        .o_right_y      (o_right_y),
        .o_pair_valid   (o_pair_valid),
        .o_bars_dropped (o_bars_dropped),
        .o_last_pair    (o_last_pair)
    );

endmodule

/* hdl/lbpm_ram.sv */
// ----------------------------------------------------------------------------
// lbpm_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module lbpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

/* hdl/lbpm_front.sv */
// ----------------------------------------------------------------------------
// lbpm_front
// Bar loader: writes bars into the current bank, counts them, flags
// overflow and hands each closed set to the sweep queue.
// ----------------------------------------------------------------------------
module lbpm_front import lbpm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_bar              i_bar,
    input  logic              i_last_bar,
    output logic              o_we,
    output logic [RAM_AW-1:0] o_waddr,
    output t_bar              o_wdata,
    output logic              o_push,
    output t_set              o_set,
    input  logic              i_done
);

    logic [CNT_W-1:0]  r_count;
    logic              r_ovf;
    logic [BANK_W-1:0] r_bank;
    // sets queued or under sweep; each holds a bank
    logic [OUT_W-1:0]  r_outst;

    logic              w_accept;
    logic              w_fits;
    logic [CNT_W-1:0]  n_count;
    logic              n_ovf;

    always_comb begin
        o_in_stall = (r_outst == OUT_W'(NUM_BANKS));
        w_accept   = i_in_valid && !o_in_stall;
        w_fits     = (r_count < CNT_W'(MAX_BARS));
        n_count    = w_fits ? r_count + CNT_W'(1) : r_count;
        n_ovf      = r_ovf | !w_fits;
        o_we       = w_accept && w_fits;
        o_waddr    = {r_bank, r_count[IDX_W-1:0]};
        o_wdata    = i_bar;
        o_push     = w_accept && i_last_bar;
        o_set      = '{bank: r_bank, count: n_count, ovf: n_ovf};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_bank  <= '0;
            r_outst <= '0;
        end else begin
            if (w_accept) begin
                if (i_last_bar) begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                    r_bank  <= r_bank + BANK_W'(1);
                end else begin
                    r_count <= n_count;
                    r_ovf   <= n_ovf;
                end
            end
            if (o_push && !i_done) begin
                r_outst <= r_outst + OUT_W'(1);
            end else if (!o_push && i_done) begin
                r_outst <= r_outst - OUT_W'(1);
            end
        end
    end

endmodule

/* hdl/lbpm_queue.sv */
// ----------------------------------------------------------------------------
// lbpm_queue
// Short FIFO of closed sets between the loader and the sweep.
// ----------------------------------------------------------------------------
module lbpm_queue import lbpm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_set i_set,
    input  logic i_pop,
    output logic o_empty,
    output t_set o_head
);

    t_set              r_mem [NUM_BANKS];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [OUT_W-1:0]  r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + OUT_W'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - OUT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_set;
        end
    end

endmodule

/* hdl/lbpm_back.sv */
// ----------------------------------------------------------------------------
// lbpm_back
// Pair sweep: tests pairs i<j of one set in a pipeline and emits kept pairs,
// holding the newest back so the final one (or an empty end) gets last_pair.
// ----------------------------------------------------------------------------
module lbpm_back import lbpm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_q_empty,
    input  t_set                  i_q_head,
    output logic                  o_q_pop,
    output logic                  o_re,
    output logic [RAM_AW-1:0]     o_raddr_a,
    output logic [RAM_AW-1:0]     o_raddr_b,
    input  t_bar                  i_bar_a,
    input  t_bar                  i_bar_b,
    output logic                  o_done,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [IDX_W-1:0]      o_left_index,
    output logic [IDX_W-1:0]      o_right_index,
    output logic [COORD_W-1:0]    o_left_x,
    output logic [COORD_W-1:0]    o_left_y,
    output logic [COORD_W-1:0]    o_right_x,
    output logic [COORD_W-1:0]    o_right_y,
    output logic                  o_pair_valid,
    output logic                  o_bars_dropped,
    output logic                  o_last_pair
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic [IDX_W-1:0]   li;
        logic [IDX_W-1:0]   ri;
        logic [COORD_W-1:0] lx;
        logic [COORD_W-1:0] ly;
        logic [COORD_W-1:0] rx;
        logic [COORD_W-1:0] ry;
        logic               pair_valid;
        logic               dropped;
        logic               last;
    } t_result;

    // configuration
    logic [DIST_W-1:0]  r_min_dist;
    logic [DIST_W-1:0]  r_max_dist;
    logic [DIST_W-1:0]  r_max_hdiff;
    logic [ADIFF_W-1:0] r_ang_low;
    logic [ADIFF_W-1:0] r_ang_high;
    logic [SQ_W-1:0]    r_lo2;
    logic [SQ_W-1:0]    r_hi2;

    // sequencer
    t_state            r_state;
    logic [IDX_W-1:0]  r_i;
    logic [J_W-1:0]    r_j;
    logic [CNT_W-1:0]  r_cnt;
    logic [BANK_W-1:0] r_bank;
    logic              r_ovf;

    // pipeline: s1 = read data, s2 = differences, s3 = squares, s4 = sum
    logic               r_s1_v, r_s1_e;
    logic [IDX_W-1:0]   r_s1_i, r_s1_j;
    logic               r_s2_v, r_s2_e;
    t_result            r_s2_p;
    logic [COORD_W-1:0] r_s2_dx, r_s2_dy;
    logic [ANGLE_W:0]   r_s2_ada;
    logic               r_s3_v, r_s3_e;
    t_result            r_s3_p;
    logic [SQ_W-1:0]    r_s3_sqx, r_s3_sqy;
    logic               r_s3_hok, r_s3_aok;
    logic               r_s4_v, r_s4_e;
    t_result            r_s4_p;
    logic [SQ_W:0]      r_s4_d2;
    logic               r_s4_hok, r_s4_aok;

    logic               r_hold_v;
    t_result            r_hold;
    logic               r_out_v;
    t_result            r_out;

    logic               w_adv;
    logic               w_more;
    logic               w_iss_v, w_iss_e;
    logic               w_kept;
    logic               w_swap;
    logic signed [ANGLE_W:0] w_da;
    logic [ANGLE_W:0]   w_ada;
    t_result            w_s2_p;
    t_result            w_new;
    t_result            w_hold_last;
    t_result            w_empty;

    always_comb begin
        // whole pipeline holds while a result waits at a stalled output
        w_adv   = !(r_out_v && i_out_stall);
        w_more  = (r_j < J_W'(r_cnt));
        w_iss_v = (r_state == S_SWEEP) && w_more;
        w_iss_e = (r_state == S_SWEEP) && !w_more;
        o_q_pop = (r_state == S_IDLE) && !i_q_empty;
        o_re    = w_adv;
        o_raddr_a = {r_bank, r_i};
        o_raddr_b = {r_bank, r_j[IDX_W-1:0]};

        // x tie puts the later bar on the left
        w_swap = !(i_bar_a.x < i_bar_b.x);
        w_s2_p = '0;
        w_s2_p.li = w_swap ? r_s1_j : r_s1_i;
        w_s2_p.ri = w_swap ? r_s1_i : r_s1_j;
        w_s2_p.lx = w_swap ? i_bar_b.x : i_bar_a.x;
        w_s2_p.ly = w_swap ? i_bar_b.y : i_bar_a.y;
        w_s2_p.rx = w_swap ? i_bar_a.x : i_bar_b.x;
        w_s2_p.ry = w_swap ? i_bar_a.y : i_bar_b.y;
        w_da  = $signed({i_bar_a.angle[ANGLE_W-1], i_bar_a.angle})
              - $signed({i_bar_b.angle[ANGLE_W-1], i_bar_b.angle});
        w_ada = w_da[ANGLE_W] ? $unsigned(-w_da) : $unsigned(w_da);

        w_kept = r_s4_v && r_s4_aok && r_s4_hok
              && (r_s4_d2 >= {1'b0, r_lo2}) && (r_s4_d2 <= {1'b0, r_hi2});
        o_done = w_adv && r_s4_e;

        w_new            = r_s4_p;
        w_new.pair_valid = 1'b1;
        w_new.dropped    = r_ovf;
        w_new.last       = 1'b0;
        w_hold_last      = r_hold;
        w_hold_last.last = 1'b1;
        w_empty          = '0;
        w_empty.dropped  = r_ovf;
        w_empty.last     = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist  <= RST_MIN_DIST;
            r_max_dist  <= RST_MAX_DIST;
            r_max_hdiff <= RST_MAX_HDIFF;
            r_ang_low   <= RST_ANG_LOW;
            r_ang_high  <= RST_ANG_HIGH;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_DIST:  r_min_dist  <= i_cfg_wdata[DIST_W-1:0];
                CFG_MAX_DIST:  r_max_dist  <= i_cfg_wdata[DIST_W-1:0];
                CFG_MAX_HDIFF: r_max_hdiff <= i_cfg_wdata[DIST_W-1:0];
                CFG_ANG_LOW:   r_ang_low   <= i_cfg_wdata[ADIFF_W-1:0];
                CFG_ANG_HIGH:  r_ang_high  <= i_cfg_wdata[ADIFF_W-1:0];
                default: ;
            endcase
        end
    end

    // squared bounds follow the registers in the next cycle
    always_ff @(posedge i_clk) begin
        r_lo2 <= SQ_W'(r_min_dist) * SQ_W'(r_min_dist);
        r_hi2 <= SQ_W'(r_max_dist) * SQ_W'(r_max_dist);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_cnt   <= '0;
            r_bank  <= '0;
            r_ovf   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        r_bank  <= i_q_head.bank;
                        r_cnt   <= i_q_head.count;
                        r_ovf   <= i_q_head.ovf;
                        r_i     <= '0;
                        r_j     <= J_W'(1);
                        r_state <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    if (w_adv) begin
                        if (!w_more) begin
                            r_state <= S_DRAIN;
                        end else if (r_j + J_W'(1) < J_W'(r_cnt)) begin
                            r_j <= r_j + J_W'(1);
                        end else begin
                            r_i <= r_i + IDX_W'(1);
                            r_j <= J_W'(r_i) + J_W'(2);
                        end
                    end
                end
                S_DRAIN: begin
                    if (o_done) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v   <= 1'b0;
            r_s1_e   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_s2_e   <= 1'b0;
            r_s3_v   <= 1'b0;
            r_s3_e   <= 1'b0;
            r_s4_v   <= 1'b0;
            r_s4_e   <= 1'b0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (w_adv) begin
                r_s1_v <= w_iss_v;
                r_s1_e <= w_iss_e;
                r_s2_v <= r_s1_v;
                r_s2_e <= r_s1_e;
                r_s3_v <= r_s2_v;
                r_s3_e <= r_s2_e;
                r_s4_v <= r_s3_v;
                r_s4_e <= r_s3_e;
                if (w_kept) begin
                    r_hold_v <= 1'b1;
                end else if (r_s4_e) begin
                    r_hold_v <= 1'b0;
                end
            end
            if (w_adv && ((w_kept && r_hold_v) || r_s4_e)) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_i   <= r_i;
            r_s1_j   <= r_j[IDX_W-1:0];

            r_s2_p   <= w_s2_p;
            r_s2_dx  <= (i_bar_a.x > i_bar_b.x) ? i_bar_a.x - i_bar_b.x
                                                : i_bar_b.x - i_bar_a.x;
            r_s2_dy  <= (i_bar_a.y > i_bar_b.y) ? i_bar_a.y - i_bar_b.y
                                                : i_bar_b.y - i_bar_a.y;
            r_s2_ada <= w_ada;

            r_s3_p   <= r_s2_p;
            r_s3_sqx <= SQ_W'(r_s2_dx) * SQ_W'(r_s2_dx);
            r_s3_sqy <= SQ_W'(r_s2_dy) * SQ_W'(r_s2_dy);
            r_s3_hok <= (r_s2_dy <= r_max_hdiff);
            r_s3_aok <= !((r_s2_ada > {1'b0, r_ang_low})
                       && (r_s2_ada < {1'b0, r_ang_high}));

            r_s4_p   <= r_s3_p;
            r_s4_d2  <= {1'b0, r_s3_sqx} + {1'b0, r_s3_sqy};
            r_s4_hok <= r_s3_hok;
            r_s4_aok <= r_s3_aok;

            // newest kept pair waits in hold until the next one or the set end
            if (w_kept) begin
                r_hold <= w_new;
                if (r_hold_v) begin
                    r_out <= r_hold;
                end
            end else if (r_s4_e) begin
                r_out <= r_hold_v ? w_hold_last : w_empty;
            end
        end
    end

    assign o_out_valid    = r_out_v;
    assign o_left_index   = r_out.li;
    assign o_right_index  = r_out.ri;
    assign o_left_x       = r_out.lx;
    assign o_left_y       = r_out.ly;
    assign o_right_x      = r_out.rx;
    assign o_right_y      = r_out.ry;
    assign o_pair_valid   = r_out.pair_valid;
    assign o_bars_dropped = r_out.dropped;
    assign o_last_pair    = r_out.last;

endmodule
